// ===== design/rctm_pkg.sv =====
// ----------------------------------------------------------------------------
// rctm_pkg
// Shared types, widths and helpers of the raycast column texel mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package rctm_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int MAX_SCREEN_DIM = 4096;
  localparam int MAX_TEX_DIM    = 1024;

  localparam int COL_W     = 12;
  localparam int ROW_W     = 12;
  localparam int DIR_W     = 18;
  localparam int POS_W     = 24;
  localparam int LH_W      = 16;
  localparam int SH_W      = 13;
  localparam int TEX_W     = 11;
  localparam int COLOR_W   = 24;
  localparam int TEXEL_W   = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  // Divider operands: numerator of the row mapping times the texture height.
  localparam int DVD_W = LH_W + TEX_W;
  localparam int REM_W = LH_W;

  localparam int IN_FIELDS_W  = COL_W + ROW_W + 2 * DIR_W + 3 * POS_W + LH_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = COL_W + ROW_W + 2 + 2 * TEXEL_W + COLOR_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    REGION_CEILING = 2'd0,
    REGION_WALL    = 2'd1,
    REGION_FLOOR   = 2'd2
  } region_t;

  typedef enum logic [1:0] {
    FACE_NORTH = 2'd0,
    FACE_SOUTH = 2'd1,
    FACE_WEST  = 2'd2,
    FACE_EAST  = 2'd3
  } face_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_HEIGHT = 3'd0,
    CFG_TEX_WIDTH     = 3'd1,
    CFG_TEX_HEIGHT    = 3'd2,
    CFG_CEILING_COLOR = 3'd3,
    CFG_FLOOR_COLOR   = 3'd4
  } cfg_index_t;

  // Input tdata layout, first field in the lowest bits.
  typedef struct packed {
    logic [IN_DATA_W-IN_FIELDS_W-1:0] pad;
    logic [LH_W-1:0]  line_height;
    logic [POS_W-1:0] perp_distance;
    logic [POS_W-1:0] camera_y;
    logic [POS_W-1:0] camera_x;
    logic [DIR_W-1:0] ray_dir_y;
    logic [DIR_W-1:0] ray_dir_x;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
  } in_data_t;

  // Output tdata layout, first field in the lowest bits.
  typedef struct packed {
    logic [OUT_DATA_W-OUT_FIELDS_W-1:0] pad;
    logic [COLOR_W-1:0] fill_color;
    logic [TEXEL_W-1:0] texel_y;
    logic [TEXEL_W-1:0] texel_x;
    face_t              face;
    logic [ROW_W-1:0]   pixel_row;
    logic [COL_W-1:0]   pixel_column;
  } out_data_t;

  // Per-pixel payload that travels down the pipeline.
  typedef struct packed {
    logic [COL_W-1:0]       column;
    logic [ROW_W-1:0]       row;
    region_t                region;
    face_t                  face;
    logic                   mirror;
    logic [FRAC_BITS-1:0]   cam_lo;
    logic [POS_W-1:0]       perp_dist;
    logic [DIR_W-1:0]       dir;
    logic [LH_W-1:0]        num;
    logic [LH_W-1:0]        lh;
    logic [COLOR_W-1:0]     fill;
    logic [2*FRAC_BITS-1:0] prod;
    logic [2*FRAC_BITS-1:0] frac;
    logic [TEX_W-1:0]       tx;
    logic [DVD_W-1:0]       dvd;
    logic [REM_W-1:0]       rem;
    logic [TEX_W-1:0]       quo;
  } pix_t;

  function automatic logic [SH_W-1:0] clamp_screen(input logic [SH_W-1:0] v);
    logic [SH_W-1:0] r;
    if (v == '0) begin
      r = SH_W'(1);
    end else if (v > SH_W'(MAX_SCREEN_DIM)) begin
      r = SH_W'(MAX_SCREEN_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [TEX_W-1:0] clamp_tex(input logic [TEX_W-1:0] v);
    logic [TEX_W-1:0] r;
    if (v == '0) begin
      r = TEX_W'(1);
    end else if (v > TEX_W'(MAX_TEX_DIM)) begin
      r = TEX_W'(MAX_TEX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/raycast_column_texel_mapper_top.sv =====
// ----------------------------------------------------------------------------
// raycast_column_texel_mapper_top
// Maps one screen pixel of a raycast column to ceiling, wall or floor and
// gives wall texel coordinates or the fill color.
// Depth: nine register stages; a request is registered into stage 0 and its
//   result shows on out_tvalid from stage 8. The depth is set mostly by the
//   restoring divider for the texture row, which runs two quotient bits per
//   stage over six stages.
// Throughput: one request per cycle while out_tready is high; fully pipelined.
// Reset: rst_n is synchronous and active low; it empties the pipeline and
//   the input skid register and loads the configuration reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module raycast_column_texel_mapper_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input requests.
  input  wire logic                          in_tvalid,
  output      logic                          in_tready,
  // tdata, lowest bit up: column, row, ray_dir_x, ray_dir_y, camera_x,
  // camera_y, perp_distance, line_height, zero fill.
  input  wire logic [rctm_pkg::IN_DATA_W-1:0] in_tdata,
  // tuser: hit_side.
  input  wire logic                          in_tuser,
  // Results.
  output      logic                          out_tvalid,
  input  wire logic                          out_tready,
  // tdata, lowest bit up: pixel_column, pixel_row, face, texel_x, texel_y,
  // fill_color, zero fill.
  output      logic [rctm_pkg::OUT_DATA_W-1:0] out_tdata,
  // tuser: region.
  output      logic [1:0]                    out_tuser,
  // Configuration writes.
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [rctm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rctm_pkg::CFG_DATA_W-1:0] cfg_data
);

  import rctm_pkg::*;

  // Stage map:
  //   0       classify the row against the clamped wall span, pick face,
  //           mirror flag and the hit axis operands
  //   1       distance times direction, row numerator times texture height
  //   2       fraction of the hit position, divider setup
  //   3       fraction times texture width, first divider bits
  //   4       mirroring of texel_x, divider bits
  //   5 to 8  remaining divider bits; stage 8 also masks and zeroes fields
  localparam int DIV_FIRST   = 3;
  localparam int DIV_PER_STG = 2;
  localparam int DIV_STG     = (TEX_W + DIV_PER_STG - 1) / DIV_PER_STG;
  localparam int NSTG        = DIV_FIRST + DIV_STG;
  localparam int LAST        = NSTG - 1;

  // Configuration registers.
  logic [SH_W-1:0]    screen_height_r;
  logic [TEX_W-1:0]   tex_width_r;
  logic [TEX_W-1:0]   tex_height_r;
  logic [COLOR_W-1:0] ceiling_color_r;
  logic [COLOR_W-1:0] floor_color_r;

  logic [SH_W-1:0]  h_c;
  logic [TEX_W-1:0] tw_c;
  logic [TEX_W-1:0] th_c;

  // Skid register in front of the pipeline keeps in_tready a flop.
  logic           skid_vld_r;
  logic           skid_vld_nxt;
  in_data_t       skid_dat_r;
  logic           skid_usr_r;
  logic           src_vld;
  in_data_t       src_dat;
  logic           src_usr;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG:0]   rdy;
  pix_t            pl_r   [NSTG];
  pix_t            pl_nxt [NSTG];

  out_data_t       od;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_height_r <= SH_W'(600);
      tex_width_r     <= TEX_W'(64);
      tex_height_r    <= TEX_W'(64);
      ceiling_color_r <= '0;
      floor_color_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SCREEN_HEIGHT: screen_height_r <= cfg_data[SH_W-1:0];
        CFG_TEX_WIDTH:     tex_width_r     <= cfg_data[TEX_W-1:0];
        CFG_TEX_HEIGHT:    tex_height_r    <= cfg_data[TEX_W-1:0];
        CFG_CEILING_COLOR: ceiling_color_r <= cfg_data[COLOR_W-1:0];
        CFG_FLOOR_COLOR:   floor_color_r   <= cfg_data[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Out-of-range sizes are pulled into the supported range.
  assign h_c  = clamp_screen(screen_height_r);
  assign tw_c = clamp_tex(tex_width_r);
  assign th_c = clamp_tex(tex_height_r);

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    rdy[NSTG] = out_tready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = ~vld_r[i] | rdy[i+1];
    end
  end

  assign in_tready = ~skid_vld_r;
  assign src_vld   = skid_vld_r | in_tvalid;
  assign src_dat   = skid_vld_r ? skid_dat_r : in_data_t'(in_tdata);
  assign src_usr   = skid_vld_r ? skid_usr_r : in_tuser;

  // The skid register fills when a request arrives while stage 0 is held,
  // and drains as soon as stage 0 takes it.
  always_comb begin
    if (skid_vld_r) begin
      skid_vld_nxt = ~rdy[0];
    end else begin
      skid_vld_nxt = in_tvalid & ~rdy[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_vld_r <= 1'b0;
    end else begin
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld_r) begin
      skid_dat_r <= in_data_t'(in_tdata);
      skid_usr_r <= in_tuser;
    end
  end

  always_comb begin
    vld_nxt[0] = src_vld;
    for (int i = 1; i < NSTG; i++) begin
      vld_nxt[i] = vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vld_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NSTG; i++) begin
      if (rdy[i]) begin
        pl_r[i] <= pl_nxt[i];
      end
    end
  end

  // Datapath of all stages.
  always_comb begin
    logic [LH_W-1:0]                lhf;
    logic [LH_W-1:0]                lh2;
    logic [SH_W-2:0]                half;
    logic [SH_W-1:0]                hm1;
    logic [LH_W:0]                  row_lh2;
    logic [LH_W:0]                  half_lh2;
    logic                           is_ceil;
    logic                           is_floor;
    logic signed [POS_W+DIR_W:0]    prod_full;
    logic [DVD_W-1:0]               dvd_full;
    logic [2*FRAC_BITS+TEX_W-1:0]   txf;
    logic [REM_W-1:0]               rem_v;
    logic [TEX_W-1:0]               quo_v;
    logic [REM_W:0]                 trial;
    int                             step;

    // Stage 0: the span is [half - lh/2, half + lh/2] clamped to the screen.
    // row < start reduces to row + lh/2 < half, since a start clamped to
    // zero can never be passed from below.
    lhf      = (src_dat.line_height == '0) ? LH_W'(1) : src_dat.line_height;
    lh2      = lhf >> 1;
    half     = h_c[SH_W-1:1];
    hm1      = h_c - SH_W'(1);
    row_lh2  = (LH_W+1)'(src_dat.row) + (LH_W+1)'(lh2);
    half_lh2 = (LH_W+1)'(half) + (LH_W+1)'(lh2);
    is_ceil  = row_lh2 < (LH_W+1)'(half);
    is_floor = ((LH_W+1)'(src_dat.row) > half_lh2) ||
               ((SH_W)'(src_dat.row) > hm1);

    pl_nxt[0]           = '0;
    pl_nxt[0].column    = src_dat.column;
    pl_nxt[0].row       = src_dat.row;
    pl_nxt[0].perp_dist = src_dat.perp_distance;
    pl_nxt[0].lh        = lhf;
    pl_nxt[0].num       = LH_W'(row_lh2 - (LH_W+1)'(half));
    if (is_ceil) begin
      pl_nxt[0].region = REGION_CEILING;
      pl_nxt[0].fill   = ceiling_color_r;
    end else if (is_floor) begin
      pl_nxt[0].region = REGION_FLOOR;
      pl_nxt[0].fill   = floor_color_r;
    end else begin
      pl_nxt[0].region = REGION_WALL;
      pl_nxt[0].fill   = '0;
    end
    // A vertical grid line hit runs along y, a horizontal one along x.
    if (!src_usr) begin
      pl_nxt[0].face   = src_dat.ray_dir_x[DIR_W-1] ? FACE_WEST : FACE_EAST;
      pl_nxt[0].mirror = !src_dat.ray_dir_x[DIR_W-1] && (src_dat.ray_dir_x != '0);
      pl_nxt[0].cam_lo = src_dat.camera_y[FRAC_BITS-1:0];
      pl_nxt[0].dir    = src_dat.ray_dir_y;
    end else begin
      pl_nxt[0].face   = src_dat.ray_dir_y[DIR_W-1] ? FACE_NORTH : FACE_SOUTH;
      pl_nxt[0].mirror = src_dat.ray_dir_y[DIR_W-1];
      pl_nxt[0].cam_lo = src_dat.camera_x[FRAC_BITS-1:0];
      pl_nxt[0].dir    = src_dat.ray_dir_x;
    end

    for (int i = 1; i < NSTG; i++) begin
      pl_nxt[i] = pl_r[i-1];
    end

    // Stage 1: the two products. Only the fraction of the hit matters, so
    // the low bits of distance times direction are kept.
    prod_full = $signed({1'b0, pl_r[0].perp_dist}) * $signed(pl_r[0].dir);
    dvd_full  = DVD_W'(pl_r[0].num) * DVD_W'(th_c);
    pl_nxt[1].prod = prod_full[2*FRAC_BITS-1:0];
    pl_nxt[1].dvd  = dvd_full;

    // Stage 2: the camera's integer part drops out of the fraction. The
    // quotient is at most the texture height, so the upper dividend bits
    // are already below the divisor and seed the remainder.
    pl_nxt[2].frac = {pl_r[1].cam_lo, FRAC_BITS'(0)} + pl_r[1].prod;
    pl_nxt[2].rem  = pl_r[1].dvd[DVD_W-1:TEX_W];
    pl_nxt[2].quo  = '0;

    // Stage 3: texel column is the fraction scaled by the texture width.
    txf            = (2*FRAC_BITS+TEX_W)'(pl_r[2].frac) * (2*FRAC_BITS+TEX_W)'(tw_c);
    pl_nxt[3].tx   = txf[2*FRAC_BITS+TEX_W-1:2*FRAC_BITS];

    // Stage 4: two faces read the texture right to left.
    if (pl_r[3].mirror) begin
      pl_nxt[4].tx = tw_c - TEX_W'(1) - pl_r[3].tx;
    end

    // Restoring division, one quotient bit per step.
    trial = '0;
    for (int s = DIV_FIRST; s < NSTG; s++) begin
      rem_v = pl_r[s-1].rem;
      quo_v = pl_r[s-1].quo;
      for (int k = 0; k < DIV_PER_STG; k++) begin
        step = (s - DIV_FIRST) * DIV_PER_STG + k;
        if (step < TEX_W) begin
          trial = {rem_v, pl_r[s-1].dvd[TEX_W-1-step]};
          if (trial >= {1'b0, pl_r[s-1].lh}) begin
            rem_v = REM_W'(trial - {1'b0, pl_r[s-1].lh});
            quo_v = {quo_v[TEX_W-2:0], 1'b1};
          end else begin
            rem_v = trial[REM_W-1:0];
            quo_v = {quo_v[TEX_W-2:0], 1'b0};
          end
        end
      end
      pl_nxt[s].rem = rem_v;
      pl_nxt[s].quo = quo_v;
    end

    // Last stage: wrap the texel row and clear wall fields elsewhere.
    if (pl_nxt[LAST].region == REGION_WALL) begin
      pl_nxt[LAST].quo = pl_nxt[LAST].quo & (th_c - TEX_W'(1));
    end else begin
      pl_nxt[LAST].face = FACE_NORTH;
      pl_nxt[LAST].tx   = '0;
      pl_nxt[LAST].quo  = '0;
    end
  end

  always_comb begin
    od              = '0;
    od.pixel_column = pl_r[LAST].column;
    od.pixel_row    = pl_r[LAST].row;
    od.face         = pl_r[LAST].face;
    od.texel_x      = pl_r[LAST].tx[TEXEL_W-1:0];
    od.texel_y      = pl_r[LAST].quo[TEXEL_W-1:0];
    od.fill_color   = pl_r[LAST].fill;
  end

  assign out_tvalid = vld_r[LAST];
  assign out_tdata  = od;
  assign out_tuser  = pl_r[LAST].region;

endmodule

`default_nettype wire

// ===== design/rctm_checker.sv =====
// ----------------------------------------------------------------------------
// rctm_checker
// Port-level checks of the raycast column texel mapper, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

module rctm_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [rctm_pkg::IN_DATA_W-1:0]  in_tdata,
  input wire logic                            in_tuser,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [rctm_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [1:0]                      out_tuser,
  input wire logic                            cfg_valid,
  input wire logic                            cfg_ready,
  input wire logic [rctm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input wire logic [rctm_pkg::CFG_DATA_W-1:0] cfg_data
);

  import rctm_pkg::*;

  out_data_t od;
  assign od = out_data_t'(out_tdata);

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // A held result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // Wall pixels carry no fill color.
  a_wall_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == REGION_WALL) |-> (od.fill_color == '0))
    else $error("wall pixel with a fill color");

  // Ceiling and floor pixels carry no face or texel coordinates.
  a_fill_no_texel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != REGION_WALL) |->
      (od.face == FACE_NORTH) && (od.texel_x == '0) && (od.texel_y == '0))
    else $error("ceiling or floor pixel with texel data");

endmodule

bind raycast_column_texel_mapper_top rctm_checker u_rctm_checker (.*);

`default_nettype wire
